### rtl/core/dtr_pkg.sv
// Shared types, constants and the character classifier of the DFA token recognizer.
package dtr_pkg;

  localparam int STATE_W = 6;
  localparam int CLASS_W = 5;
  localparam int BYTE_W  = 8;
  localparam int TOKEN_W = 8;

  typedef enum logic [1:0] {
    MODE_TRANS = 2'd0,
    MODE_FINAL = 2'd1,
    MODE_CHAR  = 2'd2,
    MODE_END   = 2'd3
  } mode_t;

  typedef struct packed {
    logic               ok;
    logic [CLASS_W-1:0] cls;
  } class_t;

  // 'b'..'d' is tested before the wider letter ranges
  function automatic class_t classify(input logic [BYTE_W-1:0] c);
    class_t r;
    r.ok  = 1'b1;
    r.cls = '0;
    if (c >= 8'h62 && c <= 8'h64) begin
      r.cls = 5'd2;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      r.cls = 5'd0;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.cls = 5'd3;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.cls = 5'd1;
    end else begin
      case (c)
        8'h3c: r.cls = 5'd4;   // <
        8'h3e: r.cls = 5'd5;   // >
        8'h25: r.cls = 5'd7;   // %
        8'h23: r.cls = 5'd8;   // #
        8'h5f: r.cls = 5'd9;   // _
        8'h5b: r.cls = 5'd10;  // [
        8'h5d: r.cls = 5'd11;  // ]
        8'h3b: r.cls = 5'd12;  // ;
        8'h3a: r.cls = 5'd13;  // :
        8'h2e: r.cls = 5'd14;  // .
        8'h28: r.cls = 5'd15;  // (
        8'h29: r.cls = 5'd16;  // )
        8'h2b: r.cls = 5'd17;  // +
        8'h2d: r.cls = 5'd18;  // -
        8'h2a: r.cls = 5'd19;  // *
        8'h2f: r.cls = 5'd20;  // /
        8'h40: r.cls = 5'd21;  // @
        8'h26: r.cls = 5'd22;  // &
        8'h7e: r.cls = 5'd23;  // ~
        8'h3d: r.cls = 5'd24;  // =
        8'h21: r.cls = 5'd25;  // !
        default: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

### rtl/core/dtr_ifs.sv
// Request and result channel interfaces of the DFA token recognizer.
interface dtr_req_if;
  import dtr_pkg::*;
  logic               valid;
  logic               ready;
  mode_t              mode;
  logic [STATE_W-1:0] table_state;
  logic [CLASS_W-1:0] table_class;
  logic [STATE_W-1:0] target_state;
  logic               entry_valid;
  logic               final_flag;
  logic [TOKEN_W-1:0] token_kind;
  logic [BYTE_W-1:0]  char_byte;

  modport source (
    output valid, mode, table_state, table_class, target_state,
    output entry_valid, final_flag, token_kind, char_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, table_state, table_class, target_state,
    input  entry_valid, final_flag, token_kind, char_byte,
    output ready
  );
endinterface

interface dtr_res_if;
  import dtr_pkg::*;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [TOKEN_W-1:0] token_out;

  modport source (output valid, accepted, token_out, input ready);
  modport sink (input valid, accepted, token_out, output ready);
endinterface

### rtl/core/dfa_token_recognizer_core.sv
// Top level of the DFA token recognizer: table memories, state walk and result register.
//
// Requests are accepted one per cycle while the block is not clearing or
// stalled. Transition and final-info writes go to their memories at the
// accepting edge. A character request reads the transition memory at (current
// state, class); the next state comes back in the next cycle and is forwarded
// to the following request's lookup, so strings stream at one character per
// cycle. An end request reads the final-state memory and its result is then
// registered in the output register; outside the clear sweep, requests stall
// only while that result waits for a full output register. After reset both
// memories are cleared in a sweep during which no request is accepted.
module dfa_token_recognizer_core #(
  parameter int NUM_STATES  = 64,
  parameter int CLASS_SLOTS = 32
) (
  input logic       clk,
  input logic       rst,
  dtr_req_if.sink   req,
  dtr_res_if.source res
);
  import dtr_pkg::*;

  localparam int TDEPTH = NUM_STATES * CLASS_SLOTS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int SAW    = $clog2(NUM_STATES);

  function automatic logic [TAW-1:0] tidx(input logic [STATE_W-1:0] st,
                                           input logic [CLASS_W-1:0] c);
    return TAW'(32'(st) * CLASS_SLOTS + 32'(c));
  endfunction

  logic                 clearing;
  logic [TAW-1:0]       clr_addr;

  logic [STATE_W-1:0]   cur_state;
  logic                 dead;
  logic [STATE_W-1:0]   state_next;
  logic                 dead_next;
  logic [STATE_W-1:0]   state_base;
  logic                 dead_base;

  logic                 s1_valid;
  logic                 s1_end;
  logic                 s1_dead;

  logic                 out_valid;
  logic                 out_accepted;
  logic [TOKEN_W-1:0]   out_token;

  logic                 req_fire;
  class_t               cls;
  logic                 cls_ok;
  logic                 s1_char_done;
  logic                 char_ok;
  logic                 launch_char;
  logic                 kill;
  logic                 launch_end;
  logic                 end_done;
  logic                 stall;
  logic                 res_acc;

  logic                 t_we;
  logic [TAW-1:0]       t_waddr;
  logic [STATE_W:0]     t_wdata;
  logic [STATE_W:0]     t_rdata;
  logic                 f_we;
  logic [SAW-1:0]       f_waddr;
  logic [TOKEN_W:0]     f_wdata;
  logic [TOKEN_W:0]     f_rdata;

  dtr_clear #(.DEPTH(TDEPTH)) u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clearing),
    .addr (clr_addr)
  );

  assign req_fire     = req.valid && req.ready;
  assign cls          = classify(req.char_byte);
  assign cls_ok       = cls.ok && (32'(cls.cls) < CLASS_SLOTS);

  // forward the lookup that completes this cycle
  assign s1_char_done = s1_valid && !s1_end;
  assign char_ok      = t_rdata[STATE_W] && (32'(t_rdata[STATE_W-1:0]) < NUM_STATES);
  assign state_base   = (s1_char_done && char_ok) ? t_rdata[STATE_W-1:0] : cur_state;
  assign dead_base    = s1_char_done ? !char_ok : dead;

  assign launch_char  = req_fire && (req.mode == MODE_CHAR) && !dead_base && cls_ok;
  assign kill         = req_fire && (req.mode == MODE_CHAR) && !dead_base && !cls_ok;
  assign launch_end   = req_fire && (req.mode == MODE_END);

  assign end_done     = s1_valid && s1_end && (!out_valid || res.ready);
  assign stall        = s1_valid && s1_end && !end_done;
  assign req.ready    = !clearing && !stall;

  assign state_next   = launch_end ? '0 : state_base;
  assign dead_next    = launch_end ? 1'b0 : (dead_base || kill);

  assign t_we    = clearing || (req_fire && (req.mode == MODE_TRANS) &&
                   (32'(req.table_state) < NUM_STATES) &&
                   (32'(req.table_class) < CLASS_SLOTS));
  assign t_waddr = clearing ? clr_addr : tidx(req.table_state, req.table_class);
  assign t_wdata = clearing ? '0 : {req.entry_valid, req.target_state};

  assign f_we    = clearing || (req_fire && (req.mode == MODE_FINAL) &&
                   (32'(req.table_state) < NUM_STATES));
  assign f_waddr = clearing ? clr_addr[SAW-1:0] : SAW'(req.table_state);
  assign f_wdata = clearing ? '0 : {req.final_flag, req.token_kind};

  dtr_ram #(.WIDTH(STATE_W + 1), .DEPTH(TDEPTH)) u_trans_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (launch_char),
    .raddr (tidx(state_base, cls.cls)),
    .rdata (t_rdata)
  );

  dtr_ram #(.WIDTH(TOKEN_W + 1), .DEPTH(NUM_STATES)) u_final_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (launch_end),
    .raddr (SAW'(state_base)),
    .rdata (f_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
      dead      <= 1'b0;
    end else begin
      cur_state <= state_next;
      dead      <= dead_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_end   <= 1'b0;
      s1_dead  <= 1'b0;
    end else if (launch_char || launch_end) begin
      s1_valid <= 1'b1;
      s1_end   <= launch_end;
      s1_dead  <= dead_base;
    end else if (!stall) begin
      s1_valid <= 1'b0;
    end
  end

  assign res_acc = !s1_dead && f_rdata[TOKEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (end_done) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_done) begin
      out_accepted <= res_acc;
      out_token    <= res_acc ? f_rdata[TOKEN_W-1:0] : '0;
    end
  end

  assign res.valid     = out_valid;
  assign res.accepted  = out_accepted;
  assign res.token_out = out_token;

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !out_valid)
    else $error("pipeline active during table clear");

  a_end_held: assert property (@(posedge clk) disable iff (rst)
    stall |=> s1_valid && s1_end)
    else $error("stalled end request dropped");

  a_lookup_only_live: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_end) |-> !dead)
    else $error("lookup in flight on a dead string");

  a_reject_token_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_accepted) |-> (out_token == '0))
    else $error("rejected result carries a token id");

endmodule

### rtl/core/dtr_ram.sv
// Generic simple dual-port RAM with registered read.
module dtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/core/dtr_clear.sv
// Post-reset sweep that clears every entry of the table memories.
module dtr_clear #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     rst,
  output logic                     busy,
  output logic [$clog2(DEPTH)-1:0] addr
);
  localparam int AW = $clog2(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      if (addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      addr <= addr + 1'b1;
    end
  end
endmodule
